// ----- rtl/tcpwct_pkg.sv -----
// Shared types and constants of the TCP window and congestion tracker.
// Used by the tracker and its testbench; depends on nothing else.
package tcpwct_pkg;

  localparam int SEQ_BITS_DEF   = 32;

  localparam int IN_DATA_BITS   = 96;
  localparam int OUT_DATA_BITS  = 112;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [31:0] WIN_MAX      = 32'hFFFF_FFFF;
  localparam logic [31:0] WIN_HALF     = 32'h8000_0000;
  localparam logic [31:0] WIN_START    = 32'd1;
  localparam logic [31:0] THRESH_RESET = 32'd65535;
  localparam logic [15:0] PEER_RESET   = 16'd65535;
  localparam logic [7:0]  FLAGS_DATA   = 8'h00;
  localparam logic [7:0]  FLAGS_ACK    = 8'h10;

  typedef enum logic [1:0] {
    REQ_SEND    = 2'd0,
    REQ_SEGMENT = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_OPEN    = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_ORDER   = 2'd2
  } status_t;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PEER_WIN  = 2'd1;

  typedef enum logic [2:0] {
    PH_SLOW    = 3'b001,
    PH_AVOID   = 3'b010,
    PH_RECOVER = 3'b100
  } phase_t;

  // One result item; packs into m_tdata/m_tuser at the top level.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_sequence;
    logic [31:0] out_acknowledge;
    logic [15:0] out_window;
    logic [7:0]  out_flags;
    logic [15:0] accepted_length;
    logic        emit_segment;
  } result_t;

endpackage

// ----- rtl/tcp_window_and_congestion_tracker.sv -----
// TCP window and congestion tracker: one connection, Reno-style window rules.
// Depends on tcpwct_pkg.
//
//   channel  direction  signals                         meaning
//   s_*      in         tvalid tready tdata tuser       one event (tuser = req_type)
//   m_*      out        tvalid tready tdata tuser       one result (tuser = status)
//   cfg_*    in         valid ready index data          register write
//
// Each event is handled in the cycle it is accepted: the connection state and
// the result register are updated at that edge; one event per cycle, if not stalled.
// Results pass through an output register backed by a one-entry skid register;
// s_tready drops only while both hold results that m_tready has not taken.
// Reset (synchronous) loads the registers' reset values and the connection state.
module tcp_window_and_congestion_tracker #(
  parameter int SEQ_BITS = tcpwct_pkg::SEQ_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // [15:0] send_length, [47:16] segment_number, [63:48] segment_window,
  // [79:64] segment_length, [95:80] buffer_room
  input  logic [tcpwct_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // [1:0] req_type
  input  logic [1:0]                            s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [31:0] out_sequence, [63:32] out_acknowledge, [79:64] out_window,
  // [87:80] out_flags, [103:88] accepted_length, [104] emit_segment, rest zero
  output logic [tcpwct_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  // [1:0] status
  output logic [1:0]                            m_tuser,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tcpwct_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tcpwct_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import tcpwct_pkg::*;

  // configuration
  logic [31:0] initial_threshold;
  logic [15:0] initial_peer_window;

  // connection state
  logic [31:0]         congestion_window, congestion_window_next;
  logic [31:0]         start_threshold, start_threshold_next;
  logic [SEQ_BITS-1:0] next_send_number, next_send_number_next;
  logic [SEQ_BITS-1:0] next_expected_number, next_expected_number_next;
  logic [15:0]         peer_window, peer_window_next;
  phase_t              phase, phase_next;

  // output register and skid register
  logic    out_valid, skid_valid;
  result_t out_res, skid_res, res;

  logic        push, pop;
  req_type_t   req_type;
  logic [15:0] send_length, segment_window, segment_length, buffer_room;
  logic [31:0] segment_number;
  logic [31:0] limit, grown_window;
  logic [15:0] take;
  logic [SEQ_BITS-1:0] expected_after;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign push      = s_tvalid && s_tready;
  assign pop       = out_valid && m_tready;

  assign req_type       = req_type_t'(s_tuser);
  assign send_length    = s_tdata[15:0];
  assign segment_number = s_tdata[47:16];
  assign segment_window = s_tdata[63:48];
  assign segment_length = s_tdata[79:64];
  assign buffer_room    = s_tdata[95:80];

  assign limit = (congestion_window < 32'(peer_window)) ? congestion_window
                                                        : 32'(peer_window);
  assign take  = (segment_length < buffer_room) ? segment_length : buffer_room;
  assign expected_after = next_expected_number + SEQ_BITS'(take);

  // saturating doubling for slow start
  assign grown_window = (congestion_window >= WIN_HALF) ? WIN_MAX
                                                        : {congestion_window[30:0], 1'b0};

  always_comb begin
    congestion_window_next    = congestion_window;
    start_threshold_next      = start_threshold;
    next_send_number_next     = next_send_number;
    next_expected_number_next = next_expected_number;
    peer_window_next          = peer_window;
    phase_next                = phase;
    res                       = '0;
    res.status                = ST_OK;
    case (req_type)
      REQ_SEND: begin
        if (32'(send_length) > limit) begin
          res.status = ST_REFUSED;
        end else begin
          res.out_sequence      = 32'(next_send_number);
          res.out_acknowledge   = 32'(next_expected_number);
          res.out_window        = peer_window;
          res.out_flags         = FLAGS_DATA;
          res.accepted_length   = send_length;
          res.emit_segment      = 1'b1;
          next_send_number_next = next_send_number + SEQ_BITS'(send_length);
        end
      end
      REQ_SEGMENT: begin
        if (SEQ_BITS'(segment_number) != next_expected_number) begin
          res.status = ST_ORDER;
        end else begin
          peer_window_next          = segment_window;
          next_expected_number_next = expected_after;
          res.out_sequence          = 32'(next_send_number);
          res.out_acknowledge       = 32'(expected_after);
          res.out_window            = segment_window;
          res.out_flags             = FLAGS_ACK;
          res.accepted_length       = take;
          res.emit_segment          = 1'b1;
          case (phase)
            PH_SLOW: begin
              congestion_window_next = grown_window;
              if (grown_window >= start_threshold) begin
                phase_next = PH_AVOID;
              end
            end
            PH_RECOVER: begin
              congestion_window_next = start_threshold;
              phase_next             = PH_AVOID;
            end
            default: begin
              if (congestion_window != WIN_MAX) begin
                congestion_window_next = congestion_window + 32'd1;
              end
            end
          endcase
        end
      end
      REQ_TIMEOUT: begin
        start_threshold_next   = {1'b0, congestion_window[31:1]};
        congestion_window_next = WIN_START;
        phase_next             = PH_SLOW;
      end
      default: begin
        // open: reload from the current configuration
        congestion_window_next    = WIN_START;
        start_threshold_next      = initial_threshold;
        next_send_number_next     = '0;
        next_expected_number_next = '0;
        peer_window_next          = initial_peer_window;
        phase_next                = PH_SLOW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_threshold   <= THRESH_RESET;
      initial_peer_window <= PEER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD: initial_threshold   <= cfg_data;
        CFG_PEER_WIN:  initial_peer_window <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      congestion_window    <= WIN_START;
      start_threshold      <= THRESH_RESET;
      next_send_number     <= '0;
      next_expected_number <= '0;
      peer_window          <= PEER_RESET;
      phase                <= PH_SLOW;
    end else if (push) begin
      congestion_window    <= congestion_window_next;
      start_threshold      <= start_threshold_next;
      next_send_number     <= next_send_number_next;
      next_expected_number <= next_expected_number_next;
      peer_window          <= peer_window_next;
      phase                <= phase_next;
    end
  end

  // result buffering: the skid entry fills only while the output register is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_res <= skid_res;
    end else if (push && (pop || !out_valid)) begin
      out_res <= res;
    end
    if (push && out_valid && !pop) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.status;
  assign m_tdata  = {7'd0, out_res.emit_segment, out_res.accepted_length,
                     out_res.out_flags, out_res.out_window,
                     out_res.out_acknowledge, out_res.out_sequence};

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for the TCP window and congestion tracker: random event stream,
// register settings per phase, and a per-event predictor of the connection state.
// Depends on tcpwct_pkg and tcp_window_and_congestion_tracker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tcpwct_pkg::*;

  localparam int SEQ_W = SEQ_BITS_DEF;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int RUN_PAIRS = 20;
  localparam int RANDOM_COUNT = 110;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    req_type_t   kind;
    logic [15:0] slen;
    logic [31:0] snum;
    logic [15:0] swin;
    logic [15:0] seglen;
    logic [15:0] room;
  } tcp_event_t;

  typedef enum int {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_TWO_OF_THREE,
    DRAIN_ONE_OF_FIVE
  } drain_mode_t;

  logic clk;
  logic rst;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_BITS-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  tcp_window_and_congestion_tracker #(.SEQ_BITS(SEQ_W)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predicted connection state and register copies
  logic [31:0]      reg_thresh;
  logic [15:0]      reg_peer;
  logic [31:0]      win_cwnd;
  logic [31:0]      win_thresh;
  logic [SEQ_W-1:0] snd_next;
  logic [SEQ_W-1:0] rcv_next;
  logic [15:0]      win_peer;
  phase_t           cc_phase;

  tcp_event_t event_backlog[$];
  result_t    reply_backlog[$];
  int         n_queued = 0;
  int         n_accepted = 0;
  int         n_replies = 0;
  int         fail_count = 0;
  int         cycles = 0;
  logic       in_taken = 1'b0;
  bit         quiet_sender = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;
  drain_mode_t drain_mode = DRAIN_FREE;
  int         drain_left = 0;
  int         drain_tick = 0;
  logic [SEQ_W-1:0] stim_rcv = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void reload_connection();
    win_cwnd   = WIN_START;
    win_thresh = reg_thresh;
    snd_next   = '0;
    rcv_next   = '0;
    win_peer   = reg_peer;
    cc_phase   = PH_SLOW;
  endfunction

  // Advance the predicted state by one event and return the reply it owes.
  function automatic result_t apply_event(input tcp_event_t ev);
    result_t     r;
    logic [31:0] limit;
    logic [15:0] take;
    r = '0;
    r.status = ST_OK;
    case (ev.kind)
      REQ_SEND: begin
        limit = (win_cwnd < {16'h0, win_peer}) ? win_cwnd : {16'h0, win_peer};
        if ({16'h0, ev.slen} > limit) begin
          r.status = ST_REFUSED;
        end else begin
          r.out_sequence    = 32'(snd_next);
          r.out_acknowledge = 32'(rcv_next);
          r.out_window      = win_peer;
          r.out_flags       = FLAGS_DATA;
          r.accepted_length = ev.slen;
          r.emit_segment    = 1'b1;
          snd_next = snd_next + SEQ_W'(ev.slen);
        end
      end
      REQ_SEGMENT: begin
        if (SEQ_W'(ev.snum) != rcv_next) begin
          r.status = ST_ORDER;
        end else begin
          win_peer = ev.swin;
          take = (ev.seglen < ev.room) ? ev.seglen : ev.room;
          rcv_next = rcv_next + SEQ_W'(take);
          r.out_sequence    = 32'(snd_next);
          r.out_acknowledge = 32'(rcv_next);
          r.out_window      = win_peer;
          r.out_flags       = FLAGS_ACK;
          r.accepted_length = take;
          r.emit_segment    = 1'b1;
          case (cc_phase)
            PH_SLOW: begin
              win_cwnd = (win_cwnd >= WIN_HALF) ? WIN_MAX : {win_cwnd[30:0], 1'b0};
              if (win_cwnd >= win_thresh) cc_phase = PH_AVOID;
            end
            PH_RECOVER: begin
              win_cwnd = win_thresh;
              cc_phase = PH_AVOID;
            end
            default: begin
              if (win_cwnd != WIN_MAX) win_cwnd = win_cwnd + 32'd1;
            end
          endcase
        end
      end
      REQ_TIMEOUT: begin
        win_thresh = win_cwnd >> 1;
        win_cwnd   = WIN_START;
        cc_phase   = PH_SLOW;
      end
      default: reload_connection();
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (fail_count < 100)
      $display("[%0t] reply %0d: %s expected 0x%0h, got 0x%0h", $time, n_replies, what,
               want, got);
    fail_count++;
  endtask

  // Check replies, track register writes, predict each accepted request.
  always @(posedge clk) begin
    result_t    want;
    tcp_event_t ev;
    if (rst) begin
      reg_thresh = THRESH_RESET;
      reg_peer   = PEER_RESET;
      reload_connection();
      in_taken <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (reply_backlog.size() == 0) begin
          flag_mismatch("unexpected reply, status", 32'd0, 32'(m_tuser));
        end else begin
          want = reply_backlog.pop_front();
          if (m_tuser != want.status)
            flag_mismatch("status", 32'(want.status), 32'(m_tuser));
          if (m_tdata[31:0] != want.out_sequence)
            flag_mismatch("out_sequence", want.out_sequence, m_tdata[31:0]);
          if (m_tdata[63:32] != want.out_acknowledge)
            flag_mismatch("out_acknowledge", want.out_acknowledge, m_tdata[63:32]);
          if (m_tdata[79:64] != want.out_window)
            flag_mismatch("out_window", 32'(want.out_window), 32'(m_tdata[79:64]));
          if (m_tdata[87:80] != want.out_flags)
            flag_mismatch("out_flags", 32'(want.out_flags), 32'(m_tdata[87:80]));
          if (m_tdata[103:88] != want.accepted_length)
            flag_mismatch("accepted_length", 32'(want.accepted_length),
                          32'(m_tdata[103:88]));
          if (m_tdata[104] != want.emit_segment)
            flag_mismatch("emit_segment", 32'(want.emit_segment), 32'(m_tdata[104]));
          if (m_tdata[111:105] != '0)
            flag_mismatch("padding", 32'd0, 32'(m_tdata[111:105]));
        end
        n_replies++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESHOLD: reg_thresh = cfg_data;
          CFG_PEER_WIN:  reg_peer = cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        ev.kind   = req_type_t'(s_tuser);
        ev.slen   = s_tdata[15:0];
        ev.snum   = s_tdata[47:16];
        ev.swin   = s_tdata[63:48];
        ev.seglen = s_tdata[79:64];
        ev.room   = s_tdata[95:80];
        reply_backlog.push_back(apply_event(ev));
        n_accepted++;
      end
      in_taken <= s_tvalid && s_tready;
    end
  end

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    tcp_event_t ev;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (event_backlog.size() > 0) begin
        ev = event_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {ev.room, ev.seglen, ev.swin, ev.snum, ev.slen};
        s_tuser  <= ev.kind;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = (quiet_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Reply drain: switch between free flow and several stall patterns.
  always @(negedge clk) begin
    if (drain_left == 0) begin
      drain_mode = drain_mode_t'($urandom_range(0, 3));
      drain_left = $urandom_range(8, 64);
    end else begin
      drain_left--;
    end
    drain_tick++;
    case (drain_mode)
      DRAIN_FREE:         m_tready <= 1'b1;
      DRAIN_COIN:         m_tready <= 1'($urandom_range(0, 1));
      DRAIN_TWO_OF_THREE: m_tready <= (drain_tick % 3) != 0;
      default:            m_tready <= (drain_tick % 5) == 0;
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Queue one request; follow the expected receive number so in-order segments can be built.
  task automatic queue_event(input req_type_t kind, input logic [15:0] slen,
                             input logic [31:0] snum, input logic [15:0] swin,
                             input logic [15:0] seglen, input logic [15:0] room);
    tcp_event_t ev;
    ev.kind = kind;
    ev.slen = slen;
    ev.snum = snum;
    ev.swin = swin;
    ev.seglen = seglen;
    ev.room = room;
    event_backlog.push_back(ev);
    n_queued++;
    if (kind == REQ_OPEN)
      stim_rcv = '0;
    else if (kind == REQ_SEGMENT && SEQ_W'(snum) == stim_rcv)
      stim_rcv = stim_rcv + SEQ_W'((seglen < room) ? seglen : room);
  endtask

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_random(input int count, input bit open_early);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (open_early && i == 3)
        queue_event(REQ_OPEN, 16'($urandom), $urandom, 16'($urandom), 16'($urandom),
                    16'($urandom));
      else if (pick < 45)
        queue_event(REQ_SEGMENT, 16'($urandom), 32'(stim_rcv),
                    ($urandom_range(0, 2) == 0) ? pick_length()
                                               : 16'hFFFF - 16'($urandom_range(0, 255)),
                    pick_length(), pick_length());
      else if (pick < 80)
        queue_event(REQ_SEND, pick_length(), $urandom, 16'($urandom), 16'($urandom),
                    16'($urandom));
      else if (pick < 88)
        queue_event(REQ_SEGMENT, 16'($urandom),
                    $urandom_range(0, 1) ? $urandom
                                         : 32'(stim_rcv) + $urandom_range(1, 3),
                    pick_length(), pick_length(), pick_length());
      else if (pick < 95)
        queue_event(REQ_TIMEOUT, 16'($urandom), $urandom, 16'($urandom), 16'($urandom),
                    16'($urandom));
      else
        queue_event(REQ_OPEN, 16'($urandom), $urandom, 16'($urandom), 16'($urandom),
                    16'($urandom));
    end
  endtask

  // Hold until every queued request is taken and every reply has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (n_accepted != n_queued || reply_backlog.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening under reset register values
    queue_event(REQ_SEND, 16'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    queue_event(REQ_SEND, 16'd1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_event(REQ_SEND, 16'd2, 32'd0, 16'd0, 16'd0, 16'd0);
    queue_event(REQ_SEND, 16'hFFFF, 32'd0, 16'd0, 16'd0, 16'd0);
    queue_event(REQ_SEGMENT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_event(REQ_SEGMENT, 16'd0, 32'(stim_rcv), 16'd0, 16'd100, 16'd40);
    queue_event(REQ_SEND, 16'd1, 32'd0, 16'd0, 16'd0, 16'd0);
    queue_event(REQ_SEGMENT, 16'd0, 32'(stim_rcv), 16'hFFFF, 16'd0, 16'hFFFF);
    queue_event(REQ_SEGMENT, 16'd0, 32'(stim_rcv), 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_event(REQ_SEGMENT, 16'd0, 32'(stim_rcv), 16'hFFFF, 16'd5, 16'd0);
    queue_event(REQ_SEND, 16'd2, 32'd0, 16'd0, 16'd0, 16'd0);
    queue_event(REQ_TIMEOUT, 16'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    queue_event(REQ_SEND, 16'd1, 32'd0, 16'd0, 16'd0, 16'd0);
    queue_event(REQ_SEND, 16'd2, 32'd0, 16'd0, 16'd0, 16'd0);
    queue_event(REQ_TIMEOUT, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_event(REQ_SEGMENT, 16'd0, 32'(stim_rcv), 16'd1, 16'd1, 16'd1);
    queue_event(REQ_SEGMENT, 16'd0, 32'(stim_rcv), 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_event(REQ_OPEN, 16'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    // stale number from before the open
    queue_event(REQ_SEGMENT, 16'd0, 32'd65575, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_event(REQ_SEGMENT, 16'd0, 32'(stim_rcv), 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_event(REQ_SEND, 16'hFFFF, 32'd0, 16'd0, 16'd0, 16'd0);
    queue_event(REQ_TIMEOUT, 16'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    queue_event(REQ_OPEN, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random(RANDOM_COUNT, 1'b0);
    wait_drained();

    // Lowest settings
    write_reg(CFG_THRESHOLD, 32'd0);
    write_reg(CFG_PEER_WIN, {16'($urandom), 16'h0000});
    @(posedge clk);
    queue_random(RANDOM_COUNT, 1'b1);
    wait_drained();

    // Highest settings: slow start runs towards window saturation
    write_reg(CFG_THRESHOLD, 32'hFFFF_FFFF);
    write_reg(CFG_PEER_WIN, {16'($urandom), 16'hFFFF});
    @(posedge clk);
    queue_random(RANDOM_COUNT, 1'b1);
    wait_drained();

    write_reg(CFG_PEER_WIN, $urandom);
    write_reg(CFG_THRESHOLD, $urandom);
    write_reg(CFG_SPARE_A, $urandom);
    @(posedge clk);
    queue_random(RANDOM_COUNT, 1'b1);
    wait_drained();

    write_reg(CFG_THRESHOLD, 32'($urandom_range(1, 300)));
    write_reg(CFG_SPARE_B, $urandom);
    write_reg(CFG_PEER_WIN, $urandom);
    @(posedge clk);
    queue_random(RANDOM_COUNT, 1'b1);
    wait_drained();

    // In-order run of empty segments, then full segments and sends with no gaps
    write_reg(CFG_THRESHOLD, 32'd1000);
    write_reg(CFG_PEER_WIN, 32'h0000_FFFF);
    @(posedge clk);
    quiet_sender = 1'b1;
    queue_event(REQ_OPEN, 16'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    for (int i = 0; i < 20; i++)
      queue_event(REQ_SEGMENT, 16'd0, 32'(stim_rcv), 16'hFFFF, 16'd0, 16'hFFFF);
    for (int i = 0; i < RUN_PAIRS; i++) begin
      queue_event(REQ_SEGMENT, 16'd0, 32'(stim_rcv), 16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_event(REQ_SEND, 16'hFFFF, 32'd0, 16'd0, 16'd0, 16'd0);
    end
    wait_drained();
    quiet_sender = 1'b0;
    queue_random(60, 1'b0);
    wait_drained();

    // allow for the output register and skid stage
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tcpwct_pkg.sv
rtl/tcp_window_and_congestion_tracker.sv
tb/testbench.sv
